### sv/cspp_pkg.sv
// Shared types, constants and cube arithmetic for the star-product pair merger.
package cspp_pkg;

  // Store geometry
  localparam int MAX_CUBES = 8;
  localparam int IDX_W     = $clog2(MAX_CUBES);
  localparam int CNT_W     = $clog2(MAX_CUBES + 1);
  localparam int MAX_VARS  = 16;
  localparam int POS_FIT   = 16;
  localparam int CUBE_W    = 2 * POS_FIT;
  localparam int VAR_W     = 5;

  // Position codes
  localparam logic [1:0] CODE_ZERO = 2'b00;
  localparam logic [1:0] CODE_ONE  = 2'b01;
  localparam logic [1:0] CODE_DC   = 2'b10;
  localparam logic [1:0] CODE_CONF = 2'b11;

  // Effective position limit
  localparam int POS_LIMIT = (MAX_VARS < POS_FIT) ? MAX_VARS : POS_FIT;

  typedef enum logic [1:0] {
    KIND_PAIR   = 2'd0,
    KIND_UNUSED = 2'd1,
    KIND_NOTICE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CUBE_W-1:0] cube_bits;
    logic              last_cube;
  } cube_in_t;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        first_index;
    logic [2:0]        second_index;
    logic [CUBE_W-1:0] product_bits;
    logic              last_result;
  } result_t;

  // Command handed from front to back through the queue
  typedef struct packed {
    logic [CUBE_W-1:0] cube_bits;
    logic              last_cube;
    logic              keep;
    logic [IDX_W-1:0]  slot;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAIR_RD,
    S_PAIR_EV,
    S_UNU_RD,
    S_UNU_EV,
    S_NOTE
  } back_state_t;

  // Number of positions in use
  function automatic logic [VAR_W-1:0] active_pos(input logic [VAR_W-1:0] var_count);
    return (var_count > VAR_W'(POS_LIMIT)) ? VAR_W'(POS_LIMIT) : var_count;
  endfunction

  // Code at one position; 11 reads as don't-care
  function automatic logic [1:0] code_at(input logic [CUBE_W-1:0] c, input int p);
    logic [1:0] v;
    v = c[2*p +: 2];
    return (v == CODE_CONF) ? CODE_DC : v;
  endfunction

  function automatic logic [CUBE_W-1:0] normalize(input logic [CUBE_W-1:0] c,
                                                  input logic [VAR_W-1:0] n);
    logic [CUBE_W-1:0] r;
    r = '0;
    for (int p = 0; p < POS_FIT; p++) begin
      if (VAR_W'(p) < n) r[2*p +: 2] = code_at(c, p);
    end
    return r;
  endfunction

  // Position-wise star product
  function automatic logic [CUBE_W-1:0] star_product(input logic [CUBE_W-1:0] a,
                                                     input logic [CUBE_W-1:0] b,
                                                     input logic [VAR_W-1:0] n);
    logic [CUBE_W-1:0] r;
    logic [1:0]        x;
    logic [1:0]        y;
    logic [1:0]        z;
    r = '0;
    for (int p = 0; p < POS_FIT; p++) begin
      x = code_at(a, p);
      y = code_at(b, p);
      if (x == CODE_DC)      z = y;
      else if (y == CODE_DC) z = x;
      else if (x == y)       z = x;
      else                   z = CODE_CONF;
      if (VAR_W'(p) < n) r[2*p +: 2] = z;
    end
    return r;
  endfunction

  // One bit per active position holding a 0/1 conflict
  function automatic logic [POS_FIT-1:0] conflict_mask(input logic [CUBE_W-1:0] a,
                                                       input logic [CUBE_W-1:0] b,
                                                       input logic [VAR_W-1:0] n);
    logic [POS_FIT-1:0] m;
    logic [1:0]         x;
    logic [1:0]         y;
    m = '0;
    for (int p = 0; p < POS_FIT; p++) begin
      x = code_at(a, p);
      y = code_at(b, p);
      m[p] = (VAR_W'(p) < n) && (x != CODE_DC) && (y != CODE_DC) && (x != y);
    end
    return m;
  endfunction

endpackage

### sv/cspp_front.sv
// Input side: accepts cubes and tags each with its store slot and running count.
module cspp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cspp_pkg::cube_in_t in_item,
  input  logic              q_full,
  output logic              q_wr,
  output cspp_pkg::cmd_t    q_data
);
  import cspp_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             keep;

  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;
  assign keep     = count_r < CNT_W'(MAX_CUBES);

  // Classify: store or drop, and the count once this cube is in
  always_comb begin
    q_data.cube_bits = in_item.cube_bits;
    q_data.last_cube = in_item.last_cube;
    q_data.keep      = keep;
    q_data.slot      = count_r[IDX_W-1:0];
    q_data.count     = keep ? count_r + CNT_W'(1) : count_r;
    count_nxt        = count_r;
    if (q_wr) count_nxt = in_item.last_cube ? '0 : q_data.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

### sv/cspp_queue.sv
// Two-entry command queue between front and back.
module cspp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cspp_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output cspp_pkg::cmd_t rd_data,
  output logic           empty
);
  import cspp_pkg::*;

  cmd_t       entries_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;

  assign full    = fill_r == 2'd2;
  assign empty   = fill_r == 2'd0;
  assign rd_data = entries_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (wr_en && !full) wr_ptr_r <= !wr_ptr_r;
      if (rd_en && !empty) rd_ptr_r <= !rd_ptr_r;
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) entries_r[wr_ptr_r] <= wr_data;
  end

endmodule

### sv/cspp_back.sv
// Execution side: cube store, pair evaluation, unused scan and result register.
module cspp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cspp_pkg::VAR_W-1:0]    var_count,
  input  cspp_pkg::cmd_t                q_data,
  input  logic                          q_empty,
  output logic                          q_rd,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cspp_pkg::result_t             out_result
);
  import cspp_pkg::*;

  back_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt;
  logic [IDX_W-1:0]     j_r, j_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_CUBES-1:0] used_r, used_nxt;
  logic                 any_r, any_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_r, out_nxt;

  logic [CUBE_W-1:0]    mem [MAX_CUBES];
  logic [CUBE_W-1:0]    rda_r;
  logic [CUBE_W-1:0]    rdb_r;
  logic                 mem_we;

  logic [VAR_W-1:0]     npos;
  logic [CUBE_W-1:0]    prod;
  logic [CUBE_W-1:0]    norm;
  logic                 pair_ok;
  logic                 slot_free;
  logic                 is_unused;
  logic                 later_unused;

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Cube arithmetic on the registered read data
  assign npos      = active_pos(var_count);
  assign prod      = star_product(rda_r, rdb_r, npos);
  assign norm      = normalize(rda_r, npos);
  assign pair_ok   = $onehot0(conflict_mask(rda_r, rdb_r, npos));
  assign slot_free = !out_valid_r || !out_stall;
  assign is_unused = !used_r[i_r];
  assign q_rd      = (state_r == S_IDLE) && !q_empty;

  // Any unused cube after the current scan index
  always_comb begin
    later_unused = 1'b0;
    for (int k = 0; k < MAX_CUBES; k++) begin
      if (IDX_W'(k) > i_r && CNT_W'(k) < count_r && !used_r[k]) later_unused = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    any_nxt       = any_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          mem_we    = q_data.keep;
          count_nxt = q_data.count;
          if (q_data.last_cube) begin
            i_nxt     = '0;
            j_nxt     = IDX_W'(1);
            any_nxt   = 1'b0;
            state_nxt = (q_data.count < CNT_W'(2)) ? S_UNU_RD : S_PAIR_RD;
          end
        end
      end
      S_PAIR_RD: state_nxt = S_PAIR_EV;
      S_PAIR_EV: begin
        if (!pair_ok || slot_free) begin
          if (pair_ok) begin
            out_valid_nxt        = 1'b1;
            out_nxt.kind         = KIND_PAIR;
            out_nxt.first_index  = 3'(i_r);
            out_nxt.second_index = 3'(j_r);
            out_nxt.product_bits = prod;
            out_nxt.last_result  = 1'b0;
            used_nxt[i_r]        = 1'b1;
            used_nxt[j_r]        = 1'b1;
          end
          if ({1'b0, j_r} + CNT_W'(1) < count_r) begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_PAIR_RD;
          end else if ({1'b0, i_r} + CNT_W'(2) < count_r) begin
            i_nxt     = i_r + IDX_W'(1);
            j_nxt     = i_r + IDX_W'(2);
            state_nxt = S_PAIR_RD;
          end else begin
            i_nxt     = '0;
            state_nxt = S_UNU_RD;
          end
        end
      end
      S_UNU_RD: state_nxt = S_UNU_EV;
      S_UNU_EV: begin
        if (!is_unused || slot_free) begin
          if (is_unused) begin
            out_valid_nxt        = 1'b1;
            out_nxt.kind         = KIND_UNUSED;
            out_nxt.first_index  = 3'(i_r);
            out_nxt.second_index = '0;
            out_nxt.product_bits = norm;
            out_nxt.last_result  = !later_unused;
            any_nxt              = 1'b1;
          end
          if ({1'b0, i_r} + CNT_W'(1) < count_r) begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_UNU_RD;
          end else if (any_r || is_unused) begin
            used_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NOTE;
          end
        end
      end
      S_NOTE: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.kind         = KIND_NOTICE;
          out_nxt.first_index  = '0;
          out_nxt.second_index = '0;
          out_nxt.product_bits = '0;
          out_nxt.last_result  = 1'b1;
          used_nxt             = '0;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      count_r     <= '0;
      used_r      <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Cube store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[q_data.slot] <= q_data.cube_bits;
    rda_r <= mem[i_r];
    rdb_r <= mem[j_r];
  end

  // Pair indices stay ordered during evaluation
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAIR_EV) |-> (j_r > i_r))
    else $error("pair index order broken");

  // A run always has at least one stored cube
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_r != '0))
    else $error("run started with an empty store");

  // Used flags are clear between runs
  a_used_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (used_r == '0))
    else $error("used flags left over from a previous run");

  // The all-used notice always closes a run
  a_notice_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_NOTICE) |-> out_r.last_result)
    else $error("notice without last mark");

  // Each unused-scan evaluation follows a store read or waits on the result slot
  a_scan_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNU_EV && $past(state_r) != S_UNU_RD) |-> $past(state_r) == S_UNU_EV)
    else $error("unused scan entered without a read");

endmodule

### sv/cube_star_product_pairs.sv
// Top level of the ternary-cube star-product pair merger.
// Cubes are taken one per cycle, while the queue is not full, into a
// two-entry queue and stored one per cycle by the back end while it is idle;
// a cube beyond eight is dropped. The cube marked last starts a run: each
// pair i<j is read from the store's read ports and then evaluated, then each
// stored cube is read and evaluated in the unused scan, and an all-used
// notice follows when no cube is left unused; new cubes queue up meanwhile.
// var_count may be written only while no run is active.
module cube_star_product_pairs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cspp_pkg::cube_in_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cspp_pkg::result_t          out_result,
  input  logic                       cfg_wr_en,
  input  logic [cspp_pkg::VAR_W-1:0] cfg_wr_data
);
  import cspp_pkg::*;

  logic [VAR_W-1:0] var_count_r;
  logic             q_wr;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;
  cmd_t             q_in;
  cmd_t             q_out;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= VAR_W'(16);
    end else if (cfg_wr_en) begin
      var_count_r <= cfg_wr_data;
    end
  end

  cspp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_data   (q_in)
  );

  cspp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_in),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  cspp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .var_count  (var_count_r),
    .q_data     (q_out),
    .q_empty    (q_empty),
    .q_rd       (q_rd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

endmodule
